// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the suffix automaton RTL, used by sac_dp
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define SAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define SAC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hdl/sac_pkg.sv =====
// ----------------------------------------------------------------------------
// sac_pkg
// Sizes, symbol mapping, sequencer states, datapath operations, command and status
// structs and the transition address function.
package sac_pkg;

  localparam int MAX_TEXT = 1024;
  localparam int ALPHABET = 70;
  localparam int NSTATE   = 2 * MAX_TEXT + 2;
  localparam int ST_W     = $clog2(NSTATE);
  localparam int LEN_W    = $clog2(MAX_TEXT + 1);
  localparam int BK_AW    = $clog2(MAX_TEXT + 1);
  localparam int SYM_W    = $clog2(ALPHABET);
  localparam int TR_DEPTH = NSTATE * ALPHABET;
  localparam int TR_AW    = $clog2(TR_DEPTH);
  localparam int CNT_W    = 11;
  localparam logic [ST_W-1:0] ROOT = ST_W'(1);

  typedef enum logic [5:0] {
    OP_CLEAR, OP_IDLE, OP_AP_CHK, OP_AP_NEW, OP_W1, OP_W2, OP_Q1, OP_Q2,
    OP_CP_RD, OP_CP_WR, OP_R1, OP_R2, OP_LQ, OP_LC, OP_FIN,
    OP_Q_RD, OP_Q_ST, OP_Q_DEC, OP_CNT_RD, OP_EMIT_HIT, OP_EMIT_MISS, OP_EMIT_OVF,
    OP_RC_ML_RD, OP_RC_ML, OP_RC_CLR, OP_RC_H1, OP_RC_H2, OP_RC_H3,
    OP_RC_S1, OP_RC_S2, OP_RC_O1, OP_RC_O2, OP_RC_O3,
    OP_RC_G1, OP_RC_G2, OP_RC_G3, OP_RC_G4, OP_RC_DONE
  } dp_op_t;

  typedef enum logic [5:0] {
    S_CLEAR, S_IDLE, S_AP_CHK, S_AP_NEW, S_W1, S_W2, S_Q1, S_Q2,
    S_CP_RD, S_CP_WR, S_R1, S_R2, S_LQ, S_LC, S_FIN,
    S_Q_RD, S_Q_ST, S_Q_DEC, S_CNT_RD, S_EMIT_HIT, S_EMIT_MISS, S_EMIT_OVF,
    S_RC_ML_RD, S_RC_ML, S_RC_CLR, S_RC_H1, S_RC_H2, S_RC_H3,
    S_RC_S1, S_RC_S2, S_RC_O1, S_RC_O2, S_RC_O3,
    S_RC_G1, S_RC_G2, S_RC_G3, S_RC_G4, S_RC_DONE
  } state_t;

  typedef struct packed {
    dp_op_t op;
    logic   accept;
  } cmd_t;

  typedef struct packed {
    logic in_op;
    logic full;
    logic p_zero;
    logic tr_zero;
    logic tr_eq_q;
    logic len_match;
    logic k_last;
    logic i_eq_max;
    logic i_eq_scount;
    logic i_lt2;
    logic fin;
    logic qmissed;
    logic cvalid;
    logic clr_done;
    logic out_free;
  } sts_t;

  function automatic logic [SYM_W-1:0] map_symbol(input logic [7:0] b);
    logic [7:0] d;
    begin
      d = 8'd0;
      if (b >= 8'h61 && b <= 8'h7a) begin
        d = b - 8'h61;
      end else if (b >= 8'h41 && b <= 8'h5a) begin
        d = b - 8'h41 + 8'd26;
      end else if (b >= 8'h30 && b <= 8'h39) begin
        d = b - 8'h30 + 8'd52;
      end else begin
        d = 8'(ALPHABET - 1);
      end
      return d[SYM_W-1:0];
    end
  endfunction

  function automatic logic [TR_AW-1:0] tr_addr(input logic [ST_W-1:0] row,
                                               input logic [SYM_W-1:0] col);
    return TR_AW'(row) * TR_AW'(ALPHABET) + TR_AW'(col);
  endfunction

endpackage

// ===== hdl/sac_ctrl.sv =====
// ----------------------------------------------------------------------------
// sac_ctrl
// Sequencer for clear, append, query, recount and result steps of the suffix automaton.
// ----------------------------------------------------------------------------
module sac_ctrl import sac_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:     if (sts.clr_done) state_next = S_IDLE;
      S_IDLE:      if (s_axis_tvalid) state_next = sts.in_op ? S_Q_RD : S_AP_CHK;
      S_AP_CHK:    state_next = S_AP_NEW;
      S_AP_NEW:    state_next = sts.full ? S_EMIT_OVF : S_W1;
      S_W1:        state_next = sts.p_zero ? S_FIN : S_W2;
      S_W2:        state_next = sts.tr_zero ? S_W1 : S_Q1;
      S_Q1:        state_next = S_Q2;
      S_Q2:        state_next = sts.len_match ? S_FIN : S_CP_RD;
      S_CP_RD:     state_next = S_CP_WR;
      S_CP_WR:     state_next = sts.k_last ? S_R1 : S_CP_RD;
      S_R1:        state_next = sts.p_zero ? S_LQ : S_R2;
      S_R2:        state_next = sts.tr_eq_q ? S_R1 : S_LQ;
      S_LQ:        state_next = S_LC;
      S_LC:        state_next = S_FIN;
      S_FIN:       state_next = S_IDLE;
      S_Q_RD:      state_next = S_Q_ST;
      S_Q_ST:      state_next = S_Q_DEC;
      S_Q_DEC: begin
        if (!sts.fin) state_next = S_IDLE;
        else if (sts.qmissed) state_next = S_EMIT_MISS;
        else if (!sts.cvalid) state_next = S_RC_ML_RD;
        else state_next = S_CNT_RD;
      end
      S_CNT_RD:    state_next = S_EMIT_HIT;
      S_EMIT_HIT,
      S_EMIT_MISS,
      S_EMIT_OVF:  if (sts.out_free) state_next = S_IDLE;
      S_RC_ML_RD:  state_next = S_RC_ML;
      S_RC_ML:     state_next = S_RC_CLR;
      S_RC_CLR:    if (sts.i_eq_max) state_next = S_RC_H1;
      S_RC_H1:     state_next = S_RC_H2;
      S_RC_H2:     state_next = S_RC_H3;
      S_RC_H3:     state_next = sts.i_eq_scount ? S_RC_S1 : S_RC_H1;
      S_RC_S1:     state_next = S_RC_S2;
      S_RC_S2:     state_next = sts.i_eq_max ? S_RC_O1 : S_RC_S1;
      S_RC_O1:     state_next = S_RC_O2;
      S_RC_O2:     state_next = S_RC_O3;
      S_RC_O3:     state_next = sts.i_eq_scount ? S_RC_G1 : S_RC_O1;
      S_RC_G1:     state_next = sts.i_lt2 ? S_RC_DONE : S_RC_G2;
      S_RC_G2:     state_next = S_RC_G3;
      S_RC_G3:     state_next = S_RC_G4;
      S_RC_G4:     state_next = S_RC_G1;
      S_RC_DONE:   state_next = S_CNT_RD;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.accept    = 1'b0;
    s_axis_tready = 1'b0;
    case (state)
      S_CLEAR:     cmd.op = OP_CLEAR;
      S_IDLE: begin
        cmd.op        = OP_IDLE;
        s_axis_tready = 1'b1;
        cmd.accept    = s_axis_tvalid;
      end
      S_AP_CHK:    cmd.op = OP_AP_CHK;
      S_AP_NEW:    cmd.op = OP_AP_NEW;
      S_W1:        cmd.op = OP_W1;
      S_W2:        cmd.op = OP_W2;
      S_Q1:        cmd.op = OP_Q1;
      S_Q2:        cmd.op = OP_Q2;
      S_CP_RD:     cmd.op = OP_CP_RD;
      S_CP_WR:     cmd.op = OP_CP_WR;
      S_R1:        cmd.op = OP_R1;
      S_R2:        cmd.op = OP_R2;
      S_LQ:        cmd.op = OP_LQ;
      S_LC:        cmd.op = OP_LC;
      S_FIN:       cmd.op = OP_FIN;
      S_Q_RD:      cmd.op = OP_Q_RD;
      S_Q_ST:      cmd.op = OP_Q_ST;
      S_Q_DEC:     cmd.op = OP_Q_DEC;
      S_CNT_RD:    cmd.op = OP_CNT_RD;
      S_EMIT_HIT:  cmd.op = OP_EMIT_HIT;
      S_EMIT_MISS: cmd.op = OP_EMIT_MISS;
      S_EMIT_OVF:  cmd.op = OP_EMIT_OVF;
      S_RC_ML_RD:  cmd.op = OP_RC_ML_RD;
      S_RC_ML:     cmd.op = OP_RC_ML;
      S_RC_CLR:    cmd.op = OP_RC_CLR;
      S_RC_H1:     cmd.op = OP_RC_H1;
      S_RC_H2:     cmd.op = OP_RC_H2;
      S_RC_H3:     cmd.op = OP_RC_H3;
      S_RC_S1:     cmd.op = OP_RC_S1;
      S_RC_S2:     cmd.op = OP_RC_S2;
      S_RC_O1:     cmd.op = OP_RC_O1;
      S_RC_O2:     cmd.op = OP_RC_O2;
      S_RC_O3:     cmd.op = OP_RC_O3;
      S_RC_G1:     cmd.op = OP_RC_G1;
      S_RC_G2:     cmd.op = OP_RC_G2;
      S_RC_G3:     cmd.op = OP_RC_G3;
      S_RC_G4:     cmd.op = OP_RC_G4;
      S_RC_DONE:   cmd.op = OP_RC_DONE;
      default:     cmd.op = OP_IDLE;
    endcase
  end

endmodule

// ===== hdl/sac_dp.sv =====
// ----------------------------------------------------------------------------
// sac_dp
// Automaton stores, walk registers, recount scratch and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sac_dp import sac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata
);

  logic [ST_W-1:0]  tr_mem   [TR_DEPTH];
  logic [LEN_W-1:0] len_mem  [NSTATE];
  logic [ST_W-1:0]  link_mem [NSTATE];
  logic             mark_mem [NSTATE];
  logic [CNT_W-1:0] cnt_mem  [NSTATE];
  logic [ST_W-1:0]  bkt_mem  [MAX_TEXT + 1];
  logic [ST_W-1:0]  ord_mem  [NSTATE];

  logic [ST_W-1:0]  tr_rd, link_rd, bkt_rd, ord_rd;
  logic [LEN_W-1:0] len_rd;
  logic             mark_rd;
  logic [CNT_W-1:0] cnt_rd;

  logic             tr_we, tr_re, len_we, len_re, link_we, link_re, mark_we, mark_re;
  logic             cnt_we, cnt_re, bkt_we, bkt_re, ord_we, ord_re;
  logic [TR_AW-1:0] tr_waddr, tr_raddr;
  logic [ST_W-1:0]  tr_wdata, len_waddr, len_raddr, link_waddr, link_raddr, link_wdata;
  logic [ST_W-1:0]  mark_waddr, mark_raddr, cnt_waddr, cnt_raddr, ord_waddr, ord_raddr;
  logic [ST_W-1:0]  ord_wdata, bkt_wdata;
  logic [LEN_W-1:0] len_wdata;
  logic             mark_wdata;
  logic [CNT_W-1:0] cnt_wdata;
  logic [BK_AW-1:0] bkt_waddr, bkt_raddr;

  logic [SYM_W-1:0] sym, k;
  logic             fin, qmissed, cvalid;
  logic [ST_W-1:0]  scount, last, cur, p, q, cl, i, acc, qstate;
  logic [LEN_W-1:0] plen, maxlen;
  logic [CNT_W-1:0] cu;
  logic [TR_AW-1:0] clr;
  logic             found, ovf;
  logic [CNT_W-1:0] occ;
  logic             out_free;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  assign sts.in_op       = s_axis_tuser;
  assign sts.full        = len_rd >= LEN_W'(MAX_TEXT);
  assign sts.p_zero      = p == '0;
  assign sts.tr_zero     = tr_rd == '0;
  assign sts.tr_eq_q     = tr_rd == q;
  assign sts.len_match   = (plen + LEN_W'(1)) == len_rd;
  assign sts.k_last      = k == SYM_W'(ALPHABET - 1);
  assign sts.i_eq_max    = i == ST_W'(maxlen);
  assign sts.i_eq_scount = i == scount;
  assign sts.i_lt2       = i < ST_W'(2);
  assign sts.fin         = fin;
  assign sts.qmissed     = qmissed;
  assign sts.cvalid      = cvalid;
  assign sts.clr_done    = clr == TR_AW'(TR_DEPTH - 1);
  assign sts.out_free    = out_free;

  always_comb begin
    tr_we = 1'b0; tr_re = 1'b0; tr_waddr = '0; tr_raddr = '0; tr_wdata = '0;
    len_we = 1'b0; len_re = 1'b0; len_waddr = '0; len_raddr = '0; len_wdata = '0;
    link_we = 1'b0; link_re = 1'b0; link_waddr = '0; link_raddr = '0; link_wdata = '0;
    mark_we = 1'b0; mark_re = 1'b0; mark_waddr = '0; mark_raddr = '0; mark_wdata = 1'b0;
    cnt_we = 1'b0; cnt_re = 1'b0; cnt_waddr = '0; cnt_raddr = '0; cnt_wdata = '0;
    bkt_we = 1'b0; bkt_re = 1'b0; bkt_waddr = '0; bkt_raddr = '0; bkt_wdata = '0;
    ord_we = 1'b0; ord_re = 1'b0; ord_waddr = '0; ord_raddr = '0; ord_wdata = '0;
    case (cmd.op)
      OP_CLEAR: begin
        tr_we = 1'b1; tr_waddr = clr;
        len_we = 1'b1; len_waddr = ROOT;
        link_we = 1'b1; link_waddr = ROOT;
        mark_we = 1'b1; mark_waddr = ROOT;
      end
      OP_AP_CHK, OP_RC_ML_RD: begin
        len_re = 1'b1; len_raddr = last;
      end
      OP_AP_NEW: begin
        if (!sts.full) begin
          len_we = 1'b1; len_waddr = scount + ST_W'(1); len_wdata = len_rd + LEN_W'(1);
          mark_we = 1'b1; mark_waddr = scount + ST_W'(1); mark_wdata = 1'b1;
        end
      end
      OP_W1: begin
        if (p != '0) begin
          tr_re = 1'b1; tr_raddr = tr_addr(p, sym);
          len_re = 1'b1; len_raddr = p;
          link_re = 1'b1; link_raddr = p;
        end else begin
          link_we = 1'b1; link_waddr = cur; link_wdata = ROOT;
        end
      end
      OP_W2: begin
        if (tr_rd == '0) begin
          tr_we = 1'b1; tr_waddr = tr_addr(p, sym); tr_wdata = cur;
        end
      end
      OP_Q1: begin
        len_re = 1'b1; len_raddr = q;
        link_re = 1'b1; link_raddr = q;
      end
      OP_Q2: begin
        if (sts.len_match) begin
          link_we = 1'b1; link_waddr = cur; link_wdata = q;
        end else begin
          len_we = 1'b1; len_waddr = scount + ST_W'(1); len_wdata = plen + LEN_W'(1);
          mark_we = 1'b1; mark_waddr = scount + ST_W'(1);
          link_we = 1'b1; link_waddr = scount + ST_W'(1); link_wdata = link_rd;
        end
      end
      OP_CP_RD: begin
        tr_re = 1'b1; tr_raddr = tr_addr(q, k);
      end
      OP_CP_WR: begin
        tr_we = 1'b1; tr_waddr = tr_addr(cl, k); tr_wdata = tr_rd;
      end
      OP_R1: begin
        if (p != '0) begin
          tr_re = 1'b1; tr_raddr = tr_addr(p, sym);
          link_re = 1'b1; link_raddr = p;
        end
      end
      OP_R2: begin
        if (tr_rd == q) begin
          tr_we = 1'b1; tr_waddr = tr_addr(p, sym); tr_wdata = cl;
        end
      end
      OP_LQ: begin
        link_we = 1'b1; link_waddr = q; link_wdata = cl;
      end
      OP_LC: begin
        link_we = 1'b1; link_waddr = cur; link_wdata = cl;
      end
      OP_Q_RD: begin
        if (!qmissed) begin
          tr_re = 1'b1; tr_raddr = tr_addr(qstate, sym);
        end
      end
      OP_CNT_RD: begin
        cnt_re = 1'b1; cnt_raddr = qstate;
      end
      OP_RC_CLR: begin
        bkt_we = 1'b1; bkt_waddr = i[BK_AW-1:0];
      end
      OP_RC_H1: begin
        len_re = 1'b1; len_raddr = i;
        mark_re = 1'b1; mark_raddr = i;
      end
      OP_RC_H2, OP_RC_O2: begin
        bkt_re = 1'b1; bkt_raddr = BK_AW'(len_rd);
      end
      OP_RC_H3: begin
        bkt_we = 1'b1; bkt_waddr = BK_AW'(len_rd); bkt_wdata = bkt_rd + ST_W'(1);
        cnt_we = 1'b1; cnt_waddr = i; cnt_wdata = CNT_W'(mark_rd);
      end
      OP_RC_S1: begin
        bkt_re = 1'b1; bkt_raddr = i[BK_AW-1:0];
      end
      OP_RC_S2: begin
        bkt_we = 1'b1; bkt_waddr = i[BK_AW-1:0]; bkt_wdata = acc + bkt_rd;
      end
      OP_RC_O1: begin
        len_re = 1'b1; len_raddr = i;
      end
      OP_RC_O3: begin
        ord_we = 1'b1; ord_waddr = bkt_rd; ord_wdata = i;
        bkt_we = 1'b1; bkt_waddr = BK_AW'(len_rd); bkt_wdata = bkt_rd - ST_W'(1);
      end
      OP_RC_G1: begin
        if (!sts.i_lt2) begin
          ord_re = 1'b1; ord_raddr = i;
        end
      end
      OP_RC_G2: begin
        link_re = 1'b1; link_raddr = ord_rd;
        cnt_re = 1'b1; cnt_raddr = ord_rd;
      end
      OP_RC_G3: begin
        cnt_re = 1'b1; cnt_raddr = link_rd;
      end
      OP_RC_G4: begin
        cnt_we = 1'b1; cnt_waddr = link_rd; cnt_wdata = cnt_rd + cu;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (tr_we) tr_mem[tr_waddr] <= tr_wdata;
    if (tr_re) tr_rd <= tr_mem[tr_raddr];
  end

  always_ff @(posedge clk) begin
    if (len_we) len_mem[len_waddr] <= len_wdata;
    if (len_re) len_rd <= len_mem[len_raddr];
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_waddr] <= link_wdata;
    if (link_re) link_rd <= link_mem[link_raddr];
  end

  always_ff @(posedge clk) begin
    if (mark_we) mark_mem[mark_waddr] <= mark_wdata;
    if (mark_re) mark_rd <= mark_mem[mark_raddr];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    if (cnt_re) cnt_rd <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (bkt_we) bkt_mem[bkt_waddr] <= bkt_wdata;
    if (bkt_re) bkt_rd <= bkt_mem[bkt_raddr];
  end

  always_ff @(posedge clk) begin
    if (ord_we) ord_mem[ord_waddr] <= ord_wdata;
    if (ord_re) ord_rd <= ord_mem[ord_raddr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sym <= map_symbol(s_axis_tdata);
      fin <= s_axis_tlast;
    end
    case (cmd.op)
      OP_AP_NEW: begin
        cur <= scount + ST_W'(1);
        p   <= last;
      end
      OP_W2: begin
        if (tr_rd == '0) begin
          p <= link_rd;
        end else begin
          q    <= tr_rd;
          plen <= len_rd;
        end
      end
      OP_Q2: begin
        cl <= scount + ST_W'(1);
        k  <= '0;
      end
      OP_CP_WR: k <= k + SYM_W'(1);
      OP_R2: if (tr_rd == q) p <= link_rd;
      OP_RC_ML: begin
        maxlen <= len_rd;
        i      <= '0;
      end
      OP_RC_CLR: i <= sts.i_eq_max ? ST_W'(1) : i + ST_W'(1);
      OP_RC_H3: begin
        i   <= sts.i_eq_scount ? '0 : i + ST_W'(1);
        acc <= '0;
      end
      OP_RC_S2: begin
        acc <= acc + bkt_rd;
        i   <= sts.i_eq_max ? ST_W'(1) : i + ST_W'(1);
      end
      OP_RC_O3: if (!sts.i_eq_scount) i <= i + ST_W'(1);
      OP_RC_G3: cu <= cnt_rd;
      OP_RC_G4: i <= i - ST_W'(1);
      default: begin
      end
    endcase
    if (out_free) begin
      case (cmd.op)
        OP_EMIT_HIT: begin
          found <= 1'b1; occ <= cnt_rd; ovf <= 1'b0;
        end
        OP_EMIT_MISS: begin
          found <= 1'b0; occ <= '0; ovf <= 1'b0;
        end
        OP_EMIT_OVF: begin
          found <= 1'b0; occ <= '0; ovf <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr           <= '0;
      scount        <= ROOT;
      last          <= ROOT;
      qstate        <= ROOT;
      qmissed       <= 1'b0;
      cvalid        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tready) m_axis_tvalid <= 1'b0;
      case (cmd.op)
        OP_CLEAR: clr <= clr + TR_AW'(1);
        OP_AP_NEW: begin
          if (!sts.full) begin
            scount <= scount + ST_W'(1);
            cvalid <= 1'b0;
          end
        end
        OP_Q2: if (!sts.len_match) scount <= scount + ST_W'(1);
        OP_FIN: last <= cur;
        OP_Q_ST: begin
          if (!qmissed) begin
            if (tr_rd == '0) qmissed <= 1'b1;
            else qstate <= tr_rd;
          end
        end
        OP_RC_DONE: cvalid <= 1'b1;
        OP_EMIT_HIT, OP_EMIT_MISS: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            qstate        <= ROOT;
            qmissed       <= 1'b0;
          end
        end
        OP_EMIT_OVF: if (out_free) m_axis_tvalid <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  assign m_axis_tdata = {3'b000, ovf, occ, found};

  `SAC_ASSERT(a_scount_bound, scount <= ST_W'(NSTATE - 1), "state count out of range")
  `SAC_ASSERT(a_qstate_nz, qstate != '0, "query walk on null state")
  `SAC_ASSERT(a_last_bound, last <= scount, "last state beyond state count")
  `SAC_ASSERT_IMP(a_edge_nz, tr_we && cmd.op != OP_CLEAR && cmd.op != OP_CP_WR, tr_wdata != '0, "null edge written by walk")

endmodule

// ===== hdl/suffix_automaton_substring_count.sv =====
// ----------------------------------------------------------------------------
// suffix_automaton_substring_count
// Append: read the last state's length, make the new state, then walk suffix links
// adding edges; where the walk stops on an edge, link to its target or clone it with
// a row copy and edge redirects. A byte onto a full text gets the overflow beat.
// Query byte: a transition read and state step; a final byte emits a miss or a hit
// beat, a hit first recounting end-position counts if the text grew since the last.
// Reset: a synchronous clearing pass zeroes the transition store; no item is
// accepted before it ends. One item is in flight at a time.
// ----------------------------------------------------------------------------
module suffix_automaton_substring_count import sac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // ch
  input  logic        s_axis_tuser,   // op
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // found, occurrences[10:0], overflow, pad
);

  cmd_t cmd;
  sts_t sts;

  sac_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts           (sts),
    .cmd           (cmd)
  );

  sac_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Substring count testbench
// Streams text and pattern bytes into the suffix automaton. A scoreboard
// keeps its own automaton and end-position counts and checks every result
// beat in order. Both sides idle at random; the receiver also holds off for
// a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module testbench;
  import sac_pkg::*;

  localparam int LIMIT = 10000000;

  typedef struct packed {
    logic        found;
    logic [10:0] occ;
    logic        ovf;
  } hit_t;

  class occ_board;
    int unsigned len_of[NSTATE];
    int unsigned link[NSTATE];
    int unsigned nxt[NSTATE][ALPHABET];
    bit          term[NSTATE];
    int unsigned hits[NSTATE];
    int unsigned lenb[MAX_TEXT+1];
    int unsigned order[NSTATE];
    int unsigned nstates, tail, walk;
    bit          fresh, lost;
    int          errors;
    hit_t        pending[$];

    function new();
      nstates = 1;
      tail    = 1;
      walk    = 1;
      fresh   = 0;
      lost    = 0;
      errors  = 0;
    endfunction

    function int unsigned sym_of(logic [7:0] b);
      if (b >= "a" && b <= "z") return b - "a";
      if (b >= "A" && b <= "Z") return b - "A" + 26;
      if (b >= "0" && b <= "9") return b - "0" + 52;
      return ALPHABET - 1;
    endfunction

    function void extend(int unsigned s);
      int unsigned cur, p, q, cl;
      nstates++;
      cur = nstates;
      p = tail;
      len_of[cur] = len_of[tail] + 1;
      term[cur] = 1;
      while (p > 0 && nxt[p][s] == 0) begin
        nxt[p][s] = cur;
        p = link[p];
      end
      if (p == 0) begin
        link[cur] = 1;
      end else begin
        q = nxt[p][s];
        if (len_of[p] + 1 == len_of[q]) begin
          link[cur] = q;
        end else begin
          nstates++;
          cl = nstates;
          len_of[cl] = len_of[p] + 1;
          link[cl] = link[q];
          nxt[cl] = nxt[q];
          term[cl] = 0;
          while (p > 0 && nxt[p][s] == q) begin
            nxt[p][s] = cl;
            p = link[p];
          end
          link[q] = cl;
          link[cur] = cl;
        end
      end
      tail = cur;
      fresh = 0;
    endfunction

    function void tally();
      int unsigned i, u;
      foreach (lenb[k]) lenb[k] = 0;
      for (i = 1; i <= nstates; i++) begin
        lenb[len_of[i]]++;
        hits[i] = term[i];
      end
      for (i = 1; i <= len_of[tail]; i++) lenb[i] += lenb[i-1];
      for (i = 1; i <= nstates; i++) begin
        order[lenb[len_of[i]]] = i;
        lenb[len_of[i]]--;
      end
      for (i = nstates; i >= 2; i--) begin
        u = order[i];
        hits[link[u]] += hits[u];
      end
      fresh = 1;
    endfunction

    // returns 1 when a text byte was taken into the automaton
    function bit note_beat(bit op, logic [7:0] ch, bit fin);
      int unsigned s, nx;
      hit_t h;
      s = sym_of(ch);
      if (!op) begin
        if (len_of[tail] >= MAX_TEXT) begin
          h = '{found: 1'b0, occ: '0, ovf: 1'b1};
          pending.push_back(h);
          return 0;
        end
        extend(s);
        return 1;
      end
      if (!lost) begin
        nx = nxt[walk][s];
        if (nx == 0) lost = 1;
        else walk = nx;
      end
      if (fin) begin
        if (lost) begin
          h = '{found: 1'b0, occ: '0, ovf: 1'b0};
        end else begin
          if (!fresh) tally();
          h = '{found: 1'b1, occ: (hits[walk] > 2047) ? 11'd2047 : 11'(hits[walk]),
                ovf: 1'b0};
        end
        pending.push_back(h);
        walk = 1;
        lost = 0;
      end
      return 0;
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check(logic [15:0] d);
      hit_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected beat %h", d));
        return;
      end
      want = pending.pop_front();
      if (d[0] !== want.found)
        report($sformatf("found %b, want %b", d[0], want.found));
      if (d[11:1] !== want.occ)
        report($sformatf("occurrences %0d, want %0d", d[11:1], want.occ));
      if (d[12] !== want.ovf)
        report($sformatf("overflow %b, want %b", d[12], want.ovf));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;

  occ_board   board = new();
  logic [7:0] txt[$];
  int         send_idle;
  int         recv_idle;
  bit         stall_req;
  int         hold_cnt;
  int         cycles;

  suffix_automaton_substring_count dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    m_axis_tready = 0;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) board.check(m_axis_tdata);
      if (stall_req) begin
        stall_req = 0;
        hold_cnt = 50000;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic send_beat(input bit op, input logic [7:0] ch, input bit fin);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= fin;
    do @(posedge clk); while (!s_axis_tready);
    if (board.note_beat(op, ch, fin)) txt.push_back(ch);
  endtask

  task automatic send_text(input string s, input bit tag);
    for (int i = 0; i < s.len(); i++) send_beat(1'b0, s[i], tag);
  endtask

  task automatic send_query(input logic [7:0] pat[$], input bit noisy);
    for (int i = 0; i < pat.size(); i++) begin
      if (noisy && i > 0 && $urandom_range(99) < 1) send_beat(1'b0, "a", $urandom_range(1));
      send_beat(1'b1, pat[i], i == pat.size() - 1);
    end
  endtask

  task automatic send_word(input string s);
    logic [7:0] pat[$];
    for (int i = 0; i < s.len(); i++) pat.push_back(s[i]);
    send_query(pat, 0);
  endtask

  function automatic logic [7:0] text_byte();
    int r;
    r = $urandom_range(99);
    if (r < 85) return "a" + 8'($urandom_range(2));
    return 8'($urandom_range(255));
  endfunction

  task automatic run_round(input int n_app, input int n_pat, input bit fill);
    logic [7:0] pat[$];
    int st, ln;
    for (int i = 0; i < n_app; i++) send_beat(1'b0, text_byte(), $urandom_range(1));
    if (fill) begin
      while (txt.size() < MAX_TEXT) send_beat(1'b0, text_byte(), $urandom_range(1));
      repeat (6) send_beat(1'b0, 8'($urandom_range(255)), $urandom_range(1));
    end
    for (int k = 0; k < n_pat; k++) begin
      pat = {};
      if (txt.size() > 0 && $urandom_range(99) < 75) begin
        st = $urandom_range(txt.size() - 1);
        ln = $urandom_range(1, 6);
        for (int j = st; j < txt.size() && j < st + ln; j++) pat.push_back(txt[j]);
      end else begin
        ln = $urandom_range(1, 4);
        repeat (ln) pat.push_back(($urandom_range(1)) ? text_byte()
                                                       : 8'($urandom_range(255)));
      end
      send_query(pat, 1);
    end
  endtask

  initial begin
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = 0;
    s_axis_tuser = 0;
    s_axis_tlast = 0;
    stall_req = 0;
    send_idle = 35;
    recv_idle = 65;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_text("abab", 0);
    send_text("Z9", 1);
    send_beat(1'b0, 8'hff, 0);
    send_beat(1'b0, 8'h00, 0);
    send_word("ab");
    send_word("b");
    send_word("Z9");
    send_word("x");
    send_word("abzab");
    send_beat(1'b1, "a", 0);
    send_beat(1'b0, "a", 0);
    send_beat(1'b1, "a", 1);
    send_beat(1'b1, 8'hff, 1);

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle = 65;
        recv_idle = 35;
      end else if (ph == 2) begin
        send_idle = 0;
        recv_idle = 0;
      end
      for (int r = 0; r < 4; r++) begin
        if (ph == 2 && r == 1) stall_req = 1;
        run_round($urandom_range(60, 100), 25, ph == 2 && r == 3);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== suffix_automaton_substring_count.f =====
+incdir+hdl
hdl/sac_pkg.sv
hdl/sac_ctrl.sv
hdl/sac_dp.sv
hdl/suffix_automaton_substring_count.sv
dv/testbench.sv
